[rtl/hgcs_pkg.sv]
//------------------------------------------------------------------------------
// hgcs_pkg
// Shared widths, constants and types of the scattering-cosine sampler.
//------------------------------------------------------------------------------
`default_nettype none

package hgcs_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int G_W         = 16;
	localparam int OUT_W       = 16;

	// Magnitudes of t = 2x-1 and of g.
	localparam int TM_W  = SAMPLE_BITS + 1;
	localparam int GM_W  = G_W;
	localparam int TSQ_W = 2 * TM_W;
	localparam int GSQ_W = 2 * GM_W;
	localparam int GCB_W = 3 * GM_W;
	localparam int GCB_H = GCB_W / 2;
	localparam int U_W   = 2 * SAMPLE_BITS + 1;

	// a = 1 + g*t, scaled by 2^(15+SAMPLE_BITS), and its square.
	localparam int A_W   = SAMPLE_BITS + 17;
	localparam int ASQ_W = 2 * A_W;

	// Terms of the numerator.
	localparam int P2_W = (2 * SAMPLE_BITS + 3) + GM_W;
	localparam int P3_W = GSQ_W + TM_W;
	localparam int PH_W = U_W + GCB_H;

	localparam int ACC_W = 2 * SAMPLE_BITS + 52;
	localparam int R_W   = 2 * SAMPLE_BITS + 54;

	// Quotient bits kept before saturation.
	localparam int Q_W       = OUT_W + 1;
	localparam int DIV_STEPS = Q_W;

	localparam logic [OUT_W-1:0] COS_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic [OUT_W-1:0] COS_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	typedef struct packed {
		logic           neg;
		logic           ovf;
		logic [R_W-1:0] rem;
		logic [R_W-1:0] dsh;
		logic [Q_W-1:0] quo;
	} hgcs_div_t;

endpackage

`default_nettype wire

[rtl/hgcs_if.sv]
//------------------------------------------------------------------------------
// hgcs_if
// Valid/ready channels of the scattering-cosine sampler.
//------------------------------------------------------------------------------
`default_nettype none

interface hgcs_sample_if import hgcs_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] uniform_sample;

	modport source (output valid, output uniform_sample, input ready);
	modport sink (input valid, input uniform_sample, output ready);
endinterface

interface hgcs_cos_if import hgcs_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] cos_theta;

	modport source (output valid, output cos_theta, input ready);
	modport sink (input valid, input cos_theta, output ready);
endinterface

interface hgcs_cfg_if import hgcs_pkg::*; ();
	logic           valid;
	logic           ready;
	logic [G_W-1:0] anisotropy;

	modport source (output valid, output anisotropy, input ready);
	modport sink (input valid, input anisotropy, output ready);
endinterface

`default_nettype wire

[rtl/hgcs_div_step.sv]
//------------------------------------------------------------------------------
// hgcs_div_step
// One registered step of the restoring divider: one quotient bit per stage.
//------------------------------------------------------------------------------
`default_nettype none

module hgcs_div_step import hgcs_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      en,
	input  wire logic      in_valid,
	input  wire hgcs_div_t in_d,
	output logic           out_valid,
	output hgcs_div_t      out_d
);

	hgcs_div_t nxt;
	logic      ge;

	always_comb begin
		ge       = (in_d.rem >= in_d.dsh);
		nxt.neg  = in_d.neg;
		nxt.ovf  = in_d.ovf;
		nxt.rem  = ge ? (in_d.rem - in_d.dsh) : in_d.rem;
		nxt.dsh  = in_d.dsh >> 1;
		nxt.quo  = {in_d.quo[Q_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_d <= nxt;
		end
	end

endmodule

`default_nettype wire

[rtl/henyey_greenstein_cos_sampler.sv]
//------------------------------------------------------------------------------
// henyey_greenstein_cos_sampler
// Draws a Henyey-Greenstein scattering cosine for each uniform sample.
//------------------------------------------------------------------------------
// Takes one request per clock and returns the sampled cosine in Q1.15 after six
// arithmetic stages, seventeen divider stages and the output register. The
// divider, one quotient bit per stage, sets the depth. The cosine is evaluated
// as (t + g(3+t^2)/2 + g^2 t + g^3(t^2-1)/2)/a^2 with t = 2x-1 and a = 1+g*t,
// exactly, then rounded to nearest (ties away from zero) and saturated; g = 0
// gives 2x-1. Stalls on the output hold the whole pipeline without loss, while
// empty stages still take new requests. Write the anisotropy only while no
// request is in flight.
`default_nettype none

module henyey_greenstein_cos_sampler import hgcs_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	hgcs_cfg_if.sink    cfg,
	hgcs_sample_if.sink sample,
	hgcs_cos_if.source  cosine
);

	logic [G_W-1:0] anisotropy_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anisotropy_q <= '0;
		end else if (cfg.valid) begin
			anisotropy_q <= cfg.anisotropy;
		end
	end

	// Valid bits and enables along the pipeline.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, out_v_q;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_out;
	logic div_v  [0:DIV_STEPS];
	logic div_en [0:DIV_STEPS-1];
	hgcs_div_t div_d [0:DIV_STEPS];

	assign en_out = !out_v_q || cosine.ready;
	assign en_s6  = !v_s6 || div_en[0];
	assign en_s5  = !v_s5 || en_s6;
	assign en_s4  = !v_s4 || en_s5;
	assign en_s3  = !v_s3 || en_s4;
	assign en_s2  = !v_s2 || en_s3;
	assign en_s1  = !v_s1 || en_s2;
	assign sample.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			v_s6    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= sample.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
			if (en_out) out_v_q <= div_v[DIV_STEPS];
		end
	end

	// Stage 1: sign and magnitude of t and g.
	logic [SAMPLE_BITS-1:0] x_in;
	logic [TM_W-1:0]        tm_s1;
	logic                   tneg_s1;
	logic [GM_W-1:0]        gm_s1;
	logic                   gneg_s1;

	assign x_in = sample.uniform_sample;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			tneg_s1 <= !x_in[SAMPLE_BITS-1];
			tm_s1   <= x_in[SAMPLE_BITS-1]
				? ({x_in, 1'b0} - (TM_W'(1) << SAMPLE_BITS))
				: ((TM_W'(1) << SAMPLE_BITS) - {x_in, 1'b0});
			gneg_s1 <= anisotropy_q[G_W-1];
			gm_s1   <= anisotropy_q[G_W-1] ? (GM_W'(0) - anisotropy_q) : anisotropy_q;
		end
	end

	// Stage 2: squares and a.
	logic [TSQ_W-1:0] tsq_s2;
	logic [GSQ_W-1:0] gsq_s2;
	logic [A_W-1:0]   a_s2;
	logic [TM_W-1:0]  tm_s2;
	logic [GM_W-1:0]  gm_s2;
	logic             tneg_s2, gneg_s2;
	logic [A_W-1:0]   gt_prod;

	assign gt_prod = A_W'(gm_s1 * tm_s1);

	always_ff @(posedge clk) begin
		if (en_s2) begin
			tsq_s2  <= tm_s1 * tm_s1;
			gsq_s2  <= gm_s1 * gm_s1;
			a_s2    <= (gneg_s1 ^ tneg_s1)
				? ((A_W'(1) << (15 + SAMPLE_BITS)) - gt_prod)
				: ((A_W'(1) << (15 + SAMPLE_BITS)) + gt_prod);
			tm_s2   <= tm_s1;
			gm_s2   <= gm_s1;
			tneg_s2 <= tneg_s1;
			gneg_s2 <= gneg_s1;
		end
	end

	// Stage 3: products of the numerator terms and a squared.
	logic [P2_W-1:0]  p2_s3;
	logic [P3_W-1:0]  p3_s3;
	logic [GCB_W-1:0] gcb_s3;
	logic [U_W-1:0]   u_s3;
	logic [ASQ_W-1:0] asq_s3;
	logic [TM_W-1:0]  tm_s3;
	logic             tneg_s3, gneg_s3;
	logic [P2_W-GM_W-1:0] three_plus;

	assign three_plus = (P2_W-GM_W)'(3) * ((P2_W-GM_W)'(1) << (2 * SAMPLE_BITS))
		+ (P2_W-GM_W)'(tsq_s2);

	always_ff @(posedge clk) begin
		if (en_s3) begin
			p2_s3   <= three_plus * gm_s2;
			p3_s3   <= gsq_s2 * tm_s2;
			gcb_s3  <= GCB_W'(gsq_s2 * gm_s2);
			u_s3    <= (U_W'(1) << (2 * SAMPLE_BITS)) - U_W'(tsq_s2);
			asq_s3  <= a_s2 * a_s2;
			tm_s3   <= tm_s2;
			tneg_s3 <= tneg_s2;
			gneg_s3 <= gneg_s2;
		end
	end

	// Stage 4: split cube product and first partial sum.
	logic [PH_W-1:0]         p4lo_s4, p4hi_s4;
	logic signed [ACC_W-1:0] acca_s4;
	logic [ASQ_W-1:0]        asq_s4;
	logic                    gneg_s4;
	logic [ACC_W-1:0]        t1_m, t2_m, t3_m;
	logic signed [ACC_W-1:0] t1_s, t2_s, t3_s;

	always_comb begin
		t1_m = ACC_W'(tm_s3) << (46 + SAMPLE_BITS);
		t2_m = ACC_W'(p2_s3) << 30;
		t3_m = ACC_W'(p3_s3) << (16 + SAMPLE_BITS);
		t1_s = tneg_s3 ? -$signed(t1_m) : $signed(t1_m);
		t2_s = gneg_s3 ? -$signed(t2_m) : $signed(t2_m);
		t3_s = tneg_s3 ? -$signed(t3_m) : $signed(t3_m);
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			p4lo_s4 <= u_s3 * gcb_s3[GCB_H-1:0];
			p4hi_s4 <= u_s3 * gcb_s3[GCB_W-1:GCB_H];
			acca_s4 <= t1_s + t2_s + t3_s;
			asq_s4  <= asq_s3;
			gneg_s4 <= gneg_s3;
		end
	end

	// Stage 5: full numerator.
	logic signed [ACC_W-1:0] acc_s5;
	logic [ASQ_W-1:0]        asq_s5;
	logic [ACC_W-1:0]        t4_m;

	assign t4_m = (ACC_W'(p4hi_s4) << GCB_H) + ACC_W'(p4lo_s4);

	always_ff @(posedge clk) begin
		if (en_s5) begin
			// The cubic term enters with the sign opposite to g.
			acc_s5 <= gneg_s4 ? (acca_s4 + $signed(t4_m)) : (acca_s4 - $signed(t4_m));
			asq_s5 <= asq_s4;
		end
	end

	// Stage 6: rounding offset, divisor and overflow test.
	logic [R_W-1:0] mag, pnum, dvs;
	hgcs_div_t      s6_q;

	always_comb begin
		mag  = acc_s5[ACC_W-1] ? R_W'(-acc_s5) : R_W'(acc_s5);
		pnum = (mag << 1) + (R_W'(asq_s5) << 1);
		dvs  = R_W'(asq_s5) << 2;
	end

	always_ff @(posedge clk) begin
		if (en_s6) begin
			s6_q.neg <= acc_s5[ACC_W-1];
			s6_q.ovf <= (pnum >= (dvs << Q_W));
			s6_q.rem <= pnum;
			s6_q.dsh <= dvs << (Q_W - 1);
			s6_q.quo <= '0;
		end
	end

	assign div_d[0] = s6_q;
	assign div_v[0] = v_s6;

	genvar i;
	generate
		for (i = 0; i < DIV_STEPS; i++) begin : g_div
			if (i == DIV_STEPS - 1) begin : g_last
				assign div_en[i] = !div_v[i+1] || en_out;
			end else begin : g_mid
				assign div_en[i] = !div_v[i+1] || div_en[i+1];
			end
			hgcs_div_step u_step (
				.clk       (clk),
				.arst_n    (arst_n),
				.en        (div_en[i]),
				.in_valid  (div_v[i]),
				.in_d      (div_d[i]),
				.out_valid (div_v[i+1]),
				.out_d     (div_d[i+1])
			);
		end
	endgenerate

	// Output register with saturation.
	hgcs_div_t        fin;
	logic [OUT_W-1:0] res, cos_q;

	always_comb begin
		fin = div_d[DIV_STEPS];
		if (fin.neg) begin
			res = (fin.ovf || fin.quo > Q_W'(32768)) ? COS_MIN : (OUT_W'(0) - fin.quo[OUT_W-1:0]);
		end else begin
			res = (fin.ovf || fin.quo > Q_W'(32767)) ? COS_MAX : fin.quo[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			cos_q <= res;
		end
	end

	assign cosine.valid     = out_v_q;
	assign cosine.cos_theta = cos_q;

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready) |=> v_s1)
		else $error("accepted request did not enter stage 1");

	a_s5_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && en_s6) |=> v_s6)
		else $error("item lost between stage 5 and stage 6");

	a_div_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s6 && div_en[0]) |=> div_v[1])
		else $error("item lost entering the divider");

endmodule

`default_nettype wire

[bench/henyey_greenstein_cos_sampler_test.sv]
//------------------------------------------------------------------------------
// henyey_greenstein_cos_sampler_test
// Drives uniform samples through the sampler under several anisotropy values,
// predicts each cosine with an exact wide-integer evaluation of the inverted
// Henyey-Greenstein distribution and checks the outputs in order.
//------------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module henyey_greenstein_cos_sampler_test;
	import hgcs_pkg::*;

	localparam int LATENCY = 24;

	// Predicts the sampled cosine and holds the cosines still owed by the block.
	class cosine_scoreboard;
		logic signed [15:0] gval;
		logic [15:0] pending_cos[$];
		int errors;

		function new();
			gval = 0;
			errors = 0;
		endfunction

		function logic [15:0] predict_cos(logic [15:0] x);
			logic signed [63:0] t, g, a;
			logic signed [255:0] num, den, mag, q;
			logic signed [255:0] tw, gw, tsq, full;
			logic neg;
			logic signed [16:0] res;
			t = 2 * $signed({48'd0, x}) - 64'sd65536;
			g = gval;
			tw = t;
			gw = g;
			tsq = tw * tw;
			full = 256'sd1 <<< 32;
			// Numerator terms scaled by 2^78: t, g(3+t^2)/2, g^2 t, g^3(t^2-1)/2.
			num = (tw <<< 62) + ((((256'sd3 <<< 32) + tsq) * gw) <<< 30)
				+ ((gw * gw * tw) <<< 32) + ((tsq - full) * gw * gw * gw);
			a = (64'sd1 <<< 31) + g * t;
			den = ($signed({192'd0, a}) * $signed({192'd0, a})) <<< 1;
			neg = num < 0;
			mag = neg ? -num : num;
			q = ((mag <<< 1) + den) / (den <<< 1);
			if (neg)
				res = (q > 32768) ? -17'sd32768 : -q[16:0];
			else
				res = (q > 32767) ? 17'sd32767 : q[16:0];
			return res[15:0];
		endfunction

		function void note_sample(logic [15:0] x);
			pending_cos.push_back(predict_cos(x));
		endfunction

		function void check_cos(logic [15:0] got);
			logic [15:0] want;
			if (pending_cos.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected cosine %0d", $signed(got));
				return;
			end
			want = pending_cos.pop_front();
			if (want !== got) begin
				errors++;
				if (errors <= 10)
					$display("cosine mismatch: expected %0d, got %0d (g=%0d)",
						$signed(want), $signed(got), gval);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	hgcs_cfg_if    cfg ();
	hgcs_sample_if sample ();
	hgcs_cos_if    cosine ();
	cosine_scoreboard board;
	bit drain_done = 0;

	henyey_greenstein_cos_sampler dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.sample (sample),
		.cosine (cosine)
	);

	always #5 clk = ~clk;

	initial begin
		cfg.valid = 0;
		cfg.anisotropy = 0;
		sample.valid = 0;
		sample.uniform_sample = 0;
		cosine.ready = 0;
	end

	// After each result the output side waits a random number of cycles.
	initial begin
		int stall;
		board = new();
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (cosine.valid && cosine.ready) begin
				board.check_cos(cosine.cos_theta);
				stall = $urandom_range(0, 5);
				if (stall > 0) begin
					cosine.ready <= 0;
					repeat (stall) @(posedge clk);
					cosine.ready <= 1;
				end
			end
		end
	end

	task automatic write_anisotropy(logic [15:0] g);
		@(posedge clk);
		cfg.valid <= 1;
		cfg.anisotropy <= g;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 0;
		board.gval = g;
	endtask

	task automatic send_sample(logic [15:0] x, bit busy_phase);
		int gap;
		gap = busy_phase ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			sample.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		sample.valid <= 1;
		sample.uniform_sample <= x;
		do @(posedge clk); while (!sample.ready);
		board.note_sample(x);
	endtask

	task automatic settle();
		sample.valid <= 0;
		@(posedge clk);
		while (board.pending_cos.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	initial begin
		logic [15:0] gset[$];
		logic [15:0] xd[$];
		bit busy;
		int per;
		gset = '{16'h0000, 16'h8000, 16'h7FFF, 16'h4CCD, 16'hB333, 16'h0001, 16'hFFFF,
			16'h7333, 16'h8001, 16'h199A, 16'hE666};
		xd = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFE, 16'h5555,
			16'hAAAA};
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		cosine.ready <= 1;
		// Directed: register reset value, then every setting with edge samples.
		foreach (xd[i]) send_sample(xd[i], 0);
		settle();
		per = (1050 - 8 - 80) / gset.size() - xd.size();
		foreach (gset[k]) begin
			write_anisotropy(gset[k]);
			foreach (xd[i]) send_sample(xd[i], 0);
			busy = 0;
			for (int n = 0; n < per; n++) begin
				if (n % 20 == 0)
					busy = ($urandom_range(0, 2) == 0);
				send_sample(16'($urandom_range(0, 65535)), busy);
			end
			settle();
		end
		for (int n = 0; n < 40; n++) begin
			write_anisotropy(16'($urandom_range(0, 65535)));
			send_sample(16'($urandom_range(0, 65535)), 0);
			send_sample(16'($urandom_range(0, 65535)), 1);
			settle();
		end
		drain_done = 1;
	end

	initial begin
		wait (drain_done);
		if (board.errors == 0 && board.pending_cos.size() == 0)
			$display("henyey_greenstein_cos_sampler test passed");
		else
			$display("henyey_greenstein_cos_sampler test failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("henyey_greenstein_cos_sampler test failed");
		$finish;
	end

endmodule

`default_nettype wire
